@@ rtl/core/camu_pkg.sv @@
// Shared types and codes for the CPU addressing mode unit.
package camu_pkg;

    localparam logic [3:0] M_ACC = 4'd0;
    localparam logic [3:0] M_IMP = 4'd1;
    localparam logic [3:0] M_IMM = 4'd2;
    localparam logic [3:0] M_ZPG = 4'd3;
    localparam logic [3:0] M_ZPX = 4'd4;
    localparam logic [3:0] M_ZPY = 4'd5;
    localparam logic [3:0] M_REL = 4'd6;
    localparam logic [3:0] M_ABS = 4'd7;
    localparam logic [3:0] M_ABX = 4'd8;
    localparam logic [3:0] M_ABY = 4'd9;
    localparam logic [3:0] M_IND = 4'd10;
    localparam logic [3:0] M_IZX = 4'd11;
    localparam logic [3:0] M_IZY = 4'd12;

    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    localparam logic [1:0] ST_READ = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_IDLE = 2'd2;

    localparam logic [1:0] STEP_0 = 2'd0;
    localparam logic [1:0] STEP_1 = 2'd1;
    localparam logic [1:0] STEP_2 = 2'd2;
    localparam logic [1:0] STEP_3 = 2'd3;

    typedef struct packed {
        logic        op;
        logic [3:0]  mode;
        logic [15:0] pc;
        logic [7:0]  x_index;
        logic [7:0]  y_index;
        logic [7:0]  read_data;
    } t_camu_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] address;
        logic [15:0] next_pc;
        logic        extra_cycle;
    } t_camu_out;

endpackage

@@ rtl/core/cpu_addressing_mode_unit.sv @@
// Latency: a result is valid in the cycle after its input transfer.
// Throughput: one input item per cycle while the single result register is empty
// or its result is taken; a new item is taken while a result is being taken too.
// Every input item produces exactly one result item.
// Reset (synchronous, active low) clears the busy flag, step counter,
// held mode and the result valid flag.
module cpu_addressing_mode_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  camu_pkg::t_camu_in   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output camu_pkg::t_camu_out  o_out_data
);

    logic                r_busy,     n_busy;
    logic [3:0]          r_mode,     n_mode;
    logic [1:0]          r_step,     n_step;
    logic [15:0]         r_work_pc,  n_work_pc;
    logic [7:0]          r_x,        n_x;
    logic [7:0]          r_y,        n_y;
    logic [7:0]          r_low,      n_low;
    logic [15:0]         r_pointer,  n_pointer;
    logic                r_out_valid, n_out_valid;
    camu_pkg::t_camu_out r_out,      n_out;

    logic        accept;
    logic [15:0] base;
    logic [7:0]  idx;
    logic [15:0] indexed_ea;
    logic [15:0] rel_off;
    logic [7:0]  zp_x;
    logic [7:0]  zp_y;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Shared datapath pieces for the read-data branch.
    assign base       = {i_in_data.read_data, r_low};
    assign idx        = (r_mode == camu_pkg::M_ABX) ? r_x : r_y;
    assign indexed_ea = base + {8'h00, idx};
    assign rel_off    = {{8{i_in_data.read_data[7]}}, i_in_data.read_data};
    assign zp_x       = i_in_data.read_data + r_x;
    assign zp_y       = i_in_data.read_data + r_y;

    always_comb begin
        n_busy      = r_busy;
        n_mode      = r_mode;
        n_step      = r_step;
        n_work_pc   = r_work_pc;
        n_x         = r_x;
        n_y         = r_y;
        n_low       = r_low;
        n_pointer   = r_pointer;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        if (accept) begin
            n_out_valid = 1'b1;
            n_out       = '{status: camu_pkg::ST_DONE, address: 16'h0000,
                            next_pc: r_work_pc, extra_cycle: 1'b0};
            if (i_in_data.op == camu_pkg::OP_START) begin
                n_mode    = i_in_data.mode;
                n_x       = i_in_data.x_index;
                n_y       = i_in_data.y_index;
                n_step    = camu_pkg::STEP_0;
                n_low     = 8'h00;
                n_pointer = 16'h0000;
                if (i_in_data.mode == camu_pkg::M_IMM) begin
                    n_busy            = 1'b0;
                    n_work_pc         = i_in_data.pc + 16'd1;
                    n_out.address     = i_in_data.pc;
                    n_out.next_pc     = i_in_data.pc + 16'd1;
                end else if (i_in_data.mode < camu_pkg::M_ZPG
                             || i_in_data.mode > camu_pkg::M_IZY) begin
                    n_busy        = 1'b0;
                    n_work_pc     = i_in_data.pc;
                    n_out.next_pc = i_in_data.pc;
                end else begin
                    n_busy        = 1'b1;
                    n_work_pc     = i_in_data.pc + 16'd1;
                    n_out.status  = camu_pkg::ST_READ;
                    n_out.address = i_in_data.pc;
                    n_out.next_pc = 16'h0000;
                end
            end else if (!r_busy) begin
                n_out.status  = camu_pkg::ST_IDLE;
                n_out.next_pc = 16'h0000;
            end else begin
                // Default is finishing; read requests override below.
                n_busy = 1'b0;
                n_step = camu_pkg::STEP_0;
                case (r_mode)
                    camu_pkg::M_ZPG: begin
                        n_out.address = {8'h00, i_in_data.read_data};
                    end
                    camu_pkg::M_ZPX: begin
                        n_out.address = {8'h00, zp_x};
                    end
                    camu_pkg::M_ZPY: begin
                        n_out.address = {8'h00, zp_y};
                    end
                    camu_pkg::M_REL: begin
                        n_out.address = r_work_pc + rel_off;
                    end
                    camu_pkg::M_ABS, camu_pkg::M_ABX, camu_pkg::M_ABY,
                    camu_pkg::M_IND: begin
                        case (r_step)
                            camu_pkg::STEP_0: begin
                                n_busy        = 1'b1;
                                n_step        = camu_pkg::STEP_1;
                                n_low         = i_in_data.read_data;
                                n_work_pc     = r_work_pc + 16'd1;
                                n_out.status  = camu_pkg::ST_READ;
                                n_out.address = r_work_pc;
                                n_out.next_pc = 16'h0000;
                            end
                            camu_pkg::STEP_1: begin
                                if (r_mode == camu_pkg::M_ABS) begin
                                    n_out.address = base;
                                end else if (r_mode == camu_pkg::M_IND) begin
                                    n_busy        = 1'b1;
                                    n_step        = camu_pkg::STEP_2;
                                    n_pointer     = base;
                                    n_out.status  = camu_pkg::ST_READ;
                                    n_out.address = base;
                                    n_out.next_pc = 16'h0000;
                                end else begin
                                    n_out.address     = indexed_ea;
                                    n_out.extra_cycle =
                                        (indexed_ea[15:8] != base[15:8]);
                                end
                            end
                            camu_pkg::STEP_2: begin
                                // High pointer byte stays in the same page.
                                n_busy        = 1'b1;
                                n_step        = camu_pkg::STEP_3;
                                n_low         = i_in_data.read_data;
                                n_out.status  = camu_pkg::ST_READ;
                                n_out.address = {r_pointer[15:8],
                                                 r_pointer[7:0] + 8'd1};
                                n_out.next_pc = 16'h0000;
                            end
                            default: begin
                                n_out.address = base;
                            end
                        endcase
                    end
                    camu_pkg::M_IZX, camu_pkg::M_IZY: begin
                        case (r_step)
                            camu_pkg::STEP_0: begin
                                n_busy        = 1'b1;
                                n_step        = camu_pkg::STEP_1;
                                n_pointer     = {8'h00, (r_mode == camu_pkg::M_IZX)
                                                 ? zp_x : i_in_data.read_data};
                                n_out.status  = camu_pkg::ST_READ;
                                n_out.address = n_pointer;
                                n_out.next_pc = 16'h0000;
                            end
                            camu_pkg::STEP_1: begin
                                n_busy        = 1'b1;
                                n_step        = camu_pkg::STEP_2;
                                n_low         = i_in_data.read_data;
                                n_out.status  = camu_pkg::ST_READ;
                                n_out.address = {8'h00, r_pointer[7:0] + 8'd1};
                                n_out.next_pc = 16'h0000;
                            end
                            default: begin
                                if (r_mode == camu_pkg::M_IZX) begin
                                    n_out.address = base;
                                end else begin
                                    n_out.address     = indexed_ea;
                                    n_out.extra_cycle =
                                        (indexed_ea[15:8] != base[15:8]);
                                end
                            end
                        endcase
                    end
                    default: begin
                        n_out.address = 16'h0000;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_mode      <= camu_pkg::M_ACC;
            r_step      <= camu_pkg::STEP_0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_mode      <= n_mode;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work_pc <= n_work_pc;
        r_x       <= n_x;
        r_y       <= n_y;
        r_low     <= n_low;
        r_pointer <= n_pointer;
        r_out     <= n_out;
    end

endmodule

@@ rtl/core/camu_checker.sv @@
// Port-level checker for the CPU addressing mode unit, bound into every instance of it.
module camu_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input camu_pkg::t_camu_in  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input camu_pkg::t_camu_out o_out_data
);

    // A result waiting for transfer keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // With the result register empty, the input side is always open.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty result register");

    // An immediate-mode start finishes at once at the operand address.
    a_imm_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_in_valid && o_in_ready && i_in_data.op == camu_pkg::OP_START
        && i_in_data.mode == camu_pkg::M_IMM
        |=> o_out_valid && o_out_data.status == camu_pkg::ST_DONE
        && o_out_data.address == $past(i_in_data.pc)
        && o_out_data.next_pc == $past(i_in_data.pc) + 16'd1)
        else $error("immediate mode result wrong");

    // Read requests and idle reports carry no program counter or flag.
    a_req_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == camu_pkg::ST_READ
        || o_out_data.status == camu_pkg::ST_IDLE)
        |-> o_out_data.next_pc == 16'h0000 && !o_out_data.extra_cycle)
        else $error("request carries stray fields");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status == camu_pkg::ST_READ
        || o_out_data.status == camu_pkg::ST_DONE
        || o_out_data.status == camu_pkg::ST_IDLE)
        else $error("undefined status code");

endmodule

bind cpu_addressing_mode_unit camu_checker u_camu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
